>>> hdl/hrbp_pkg.sv
// Shared types and constants for the HTTP request byte parser.
// Holds byte-class and method codes and the delimiter and method characters.
// No dependencies.
package hrbp_pkg;

    // class label given to each byte
    typedef enum logic [2:0] {
        CLS_IGNORED = 3'd0,
        CLS_METHOD  = 3'd1,
        CLS_PATH    = 3'd2,
        CLS_PROTO   = 3'd3,
        CLS_HNAME   = 3'd4,
        CLS_HVALUE  = 3'd5,
        CLS_BODY    = 3'd6
    } t_byte_class;

    // decoded request method
    typedef enum logic [1:0] {
        METH_UNKNOWN = 2'd0,
        METH_GET     = 2'd1,
        METH_POST    = 2'd2
    } t_method;

    // delimiter characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // method text characters
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_O = 8'h4F;
    localparam logic [7:0] CH_S = 8'h53;

    // method length counter width and the lengths of the known methods
    localparam int unsigned METH_LEN_BITS = 3;
    localparam logic [METH_LEN_BITS-1:0] GET_LEN  = 3'd3;
    localparam logic [METH_LEN_BITS-1:0] POST_LEN = 3'd4;

    // match flags: bit 0 GET still possible, bit 1 POST still possible
    localparam int unsigned MATCH_GET  = 0;
    localparam int unsigned MATCH_POST = 1;

    // width of the body count output
    localparam int unsigned BODY_OUT_BITS = 16;

    // expected character at a method position
    function automatic logic [7:0] get_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = CH_G;
            2'd1:    ch = CH_E;
            default: ch = CH_T;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] post_char(input logic [1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = CH_P;
            2'd1:    ch = CH_O;
            2'd2:    ch = CH_S;
            default: ch = CH_T;
        endcase
        return ch;
    endfunction

endpackage

>>> hdl/http_request_byte_parser_core.sv
// HTTP request byte parser, top level.
// Depends on hrbp_pkg for class codes, method codes and character constants.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) takes one raw request byte per
//    item, with i_in_last set on the final byte of a request.
//  - Output channel (o_out_valid / i_out_ready) gives one result item per
//    input item: the byte, its class, a field-end flag, the method decoded
//    so far, the sticky method-length error and the saturated body count.
//  - The result of an item is registered when it is accepted and shown in
//    the output register from the next cycle on.
//  - Throughput is one item per cycle while i_out_ready is high; the parse
//    state machine and body counter update in the cycle the item is accepted.
//  - o_in_ready is high while the output register is empty or its item is
//    being taken in the same cycle; a stalled receiver holds the result and
//    backs the input up after at most one item.
//  - After the item that carries i_in_last, all parse state returns to the
//    start of a request.
//  - Reset (i_rst_n low, synchronous) empties the output register and
//    returns the parser to the start of a request; no clearing pass.
//  - BODY_COUNT_BITS sets the internal body counter width; the output shows
//    the count clipped to 16 bits.
module http_request_byte_parser_core #(
    parameter int unsigned BODY_COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [2:0]  o_byte_class,
    output logic        o_field_end,
    output logic [1:0]  o_method_code,
    output logic        o_method_error,
    output logic [15:0] o_body_count,
    output logic        o_out_last
);

    localparam int unsigned CNT_EXT_BITS = 32;

    typedef enum logic [2:0] {
        ST_START  = 3'd0,
        ST_METHOD = 3'd1,
        ST_PATH   = 3'd2,
        ST_GAP    = 3'd3,
        ST_PROTO  = 3'd4,
        ST_HNAME  = 3'd5,
        ST_HVALUE = 3'd6,
        ST_BODY   = 3'd7
    } t_parse_state;

    // parse state
    t_parse_state                           r_state, n_state;
    logic [hrbp_pkg::METH_LEN_BITS-1:0]     r_mlen, n_mlen;
    logic [1:0]                             r_match, n_match;
    hrbp_pkg::t_method                      r_method, n_method;
    logic                                   r_lead, n_lead;
    logic                                   r_err, n_err;
    logic [BODY_COUNT_BITS-1:0]             r_body_cnt, n_body_cnt;

    // output register
    logic                                   r_out_valid;
    logic [7:0]                             r_out_byte;
    hrbp_pkg::t_byte_class                  r_out_class;
    logic                                   r_out_fend;
    hrbp_pkg::t_method                      r_out_method;
    logic                                   r_out_err;
    logic [hrbp_pkg::BODY_OUT_BITS-1:0]     r_out_count;
    logic                                   r_out_last;

    hrbp_pkg::t_byte_class                  w_class;
    logic                                   w_fend;
    logic                                   w_in_fire;
    logic [CNT_EXT_BITS-1:0]                w_cnt_ext;
    logic [hrbp_pkg::BODY_OUT_BITS-1:0]     w_count_shown;

    // accept while the output register is free or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // per-byte parse step
    always_comb begin
        n_state    = r_state;
        n_mlen     = r_mlen;
        n_match    = r_match;
        n_method   = r_method;
        n_lead     = r_lead;
        n_err      = r_err;
        n_body_cnt = r_body_cnt;
        w_class    = hrbp_pkg::CLS_IGNORED;
        w_fend     = 1'b0;

        if (!r_err) begin
            unique case (r_state)
                ST_START, ST_METHOD: begin
                    if (r_state == ST_METHOD && i_in_byte == hrbp_pkg::CH_SP) begin
                        // method closes: decode or flag a bad length
                        w_fend  = 1'b1;
                        n_state = ST_PATH;
                        if (r_mlen == hrbp_pkg::GET_LEN) begin
                            if (r_match[hrbp_pkg::MATCH_GET]) begin
                                n_method = hrbp_pkg::METH_GET;
                            end
                        end else if (r_mlen == hrbp_pkg::POST_LEN) begin
                            if (r_match[hrbp_pkg::MATCH_POST]) begin
                                n_method = hrbp_pkg::METH_POST;
                            end
                        end else begin
                            n_err = 1'b1;
                        end
                    end else begin
                        // method character: narrow the candidates
                        w_class = hrbp_pkg::CLS_METHOD;
                        n_state = ST_METHOD;
                        if (r_mlen >= hrbp_pkg::GET_LEN
                            || i_in_byte != hrbp_pkg::get_char(r_mlen[1:0])) begin
                            n_match[hrbp_pkg::MATCH_GET] = 1'b0;
                        end
                        if (r_mlen >= hrbp_pkg::POST_LEN
                            || i_in_byte != hrbp_pkg::post_char(r_mlen[1:0])) begin
                            n_match[hrbp_pkg::MATCH_POST] = 1'b0;
                        end
                        if (r_mlen != '1) begin
                            n_mlen = r_mlen + 1'b1;
                        end
                    end
                end
                ST_PATH: begin
                    if (i_in_byte == hrbp_pkg::CH_SP) begin
                        w_fend  = 1'b1;
                        n_state = ST_GAP;
                    end else begin
                        w_class = hrbp_pkg::CLS_PATH;
                    end
                end
                ST_GAP: begin
                    // skip spaces after the path
                    if (i_in_byte != hrbp_pkg::CH_SP) begin
                        n_state = ST_PROTO;
                        if (i_in_byte != hrbp_pkg::CH_CR) begin
                            w_class = hrbp_pkg::CLS_PROTO;
                        end
                    end
                end
                ST_PROTO: begin
                    if (i_in_byte == hrbp_pkg::CH_LF) begin
                        n_state = ST_HNAME;
                    end else if (i_in_byte != hrbp_pkg::CH_CR) begin
                        w_class = hrbp_pkg::CLS_PROTO;
                    end
                end
                ST_HNAME: begin
                    // bare line feed or line without colon starts the body
                    if (i_in_byte == hrbp_pkg::CH_LF) begin
                        n_state = ST_BODY;
                    end else if (i_in_byte == hrbp_pkg::CH_COLON) begin
                        w_fend  = 1'b1;
                        n_lead  = 1'b1;
                        n_state = ST_HVALUE;
                    end else if (i_in_byte != hrbp_pkg::CH_CR) begin
                        w_class = hrbp_pkg::CLS_HNAME;
                    end
                end
                ST_HVALUE: begin
                    if (r_lead && i_in_byte == hrbp_pkg::CH_SP) begin
                        w_class = hrbp_pkg::CLS_IGNORED;
                    end else if (i_in_byte == hrbp_pkg::CH_LF) begin
                        w_fend  = 1'b1;
                        n_lead  = 1'b0;
                        n_state = ST_HNAME;
                    end else begin
                        n_lead = 1'b0;
                        if (i_in_byte != hrbp_pkg::CH_CR) begin
                            w_class = hrbp_pkg::CLS_HVALUE;
                        end
                    end
                end
                ST_BODY: begin
                    // saturating body counter
                    w_class = hrbp_pkg::CLS_BODY;
                    if (r_body_cnt != '1) begin
                        n_body_cnt = r_body_cnt + 1'b1;
                    end
                end
            endcase
        end
    end

    // clip the body count to the output width
    assign w_cnt_ext     = CNT_EXT_BITS'(n_body_cnt);
    assign w_count_shown = (|w_cnt_ext[CNT_EXT_BITS-1:hrbp_pkg::BODY_OUT_BITS])
                           ? '1 : w_cnt_ext[hrbp_pkg::BODY_OUT_BITS-1:0];

    // parse state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_START;
            r_mlen      <= '0;
            r_match     <= '1;
            r_method    <= hrbp_pkg::METH_UNKNOWN;
            r_lead      <= 1'b0;
            r_err       <= 1'b0;
            r_body_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_fire) begin
                // state returns to start after the last byte of a request
                if (i_in_last) begin
                    r_state    <= ST_START;
                    r_mlen     <= '0;
                    r_match    <= '1;
                    r_method   <= hrbp_pkg::METH_UNKNOWN;
                    r_lead     <= 1'b0;
                    r_err      <= 1'b0;
                    r_body_cnt <= '0;
                end else begin
                    r_state    <= n_state;
                    r_mlen     <= n_mlen;
                    r_match    <= n_match;
                    r_method   <= n_method;
                    r_lead     <= n_lead;
                    r_err      <= n_err;
                    r_body_cnt <= n_body_cnt;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        // result payload, loaded with each accepted item
        if (w_in_fire) begin
            r_out_byte   <= i_in_byte;
            r_out_class  <= w_class;
            r_out_fend   <= w_fend;
            r_out_method <= n_method;
            r_out_err    <= n_err;
            r_out_count  <= w_count_shown;
            r_out_last   <= i_in_last;
        end
    end

    // output ports
    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_byte_class   = r_out_class;
    assign o_field_end    = r_out_fend;
    assign o_method_code  = r_out_method;
    assign o_method_error = r_out_err;
    assign o_body_count   = r_out_count;
    assign o_out_last     = r_out_last;

    // a last byte always brings the parser back to a clean start
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && i_in_last) |=> (r_state == ST_START && !r_err
                                      && r_body_cnt == '0))
        else $error("parser not restarted after last byte");

    // the method error holds until the request ends
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !(w_in_fire && i_in_last)) |=> r_err)
        else $error("method error dropped inside a request");

    // a bad method length never comes with a decoded method
    a_err_no_method: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (r_method == hrbp_pkg::METH_UNKNOWN))
        else $error("method decoded together with a length error");

    // a field-closing byte is a delimiter and is never labeled
    a_fend_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_fend) |-> (r_out_class == hrbp_pkg::CLS_IGNORED))
        else $error("field end on a labeled byte");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty output register");

endmodule

>>> sim/http_request_byte_parser_core_test.sv
// Self-checking testbench for http_request_byte_parser_core.
// Labels every request byte with its own parser and checks each result item.
// Depends on hrbp_pkg and the top level http_request_byte_parser_core.
`timescale 1ns / 1ps

module http_request_byte_parser_core_test;

    // parser states of the label predictor
    typedef enum logic [2:0] {
        PS_START, PS_METHOD, PS_PATH, PS_GAP, PS_PROTO, PS_HNAME, PS_HVALUE, PS_BODY
    } t_parse_state;

    // one request byte waiting to be sent
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_req_byte;

    // labels expected for one byte
    typedef struct {
        logic [7:0]            data;
        hrbp_pkg::t_byte_class cls;
        logic                  fend;
        hrbp_pkg::t_method     meth;
        logic                  err;
        logic [15:0]           count;
        logic                  last;
    } t_label;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        i_in_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic [2:0]  o_byte_class;
    logic        o_field_end;
    logic [1:0]  o_method_code;
    logic        o_method_error;
    logic [15:0] o_body_count;
    logic        o_out_last;

    http_request_byte_parser_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_byte_class   (o_byte_class),
        .o_field_end    (o_field_end),
        .o_method_code  (o_method_code),
        .o_method_error (o_method_error),
        .o_body_count   (o_body_count),
        .o_out_last     (o_out_last)
    );

    // clock, 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_req_byte request_bytes[$];
    t_label    expected_labels[$];
    int        accepted = 0;
    int        total_items = 0;
    int        fail_cnt = 0;
    int        mark1 = 0;
    int        mark2 = 0;
    bit        stim_ready = 1'b0;
    bit        byte_taken = 1'b0;
    bit        rx_hold = 1'b0;

    // predictor state
    t_parse_state      pst;
    logic [2:0]        meth_len;
    logic [1:0]        meth_cand;
    hrbp_pkg::t_method meth_seen;
    logic              skip_lead;
    logic              meth_bad;
    logic [15:0]       body_cnt;

    logic [7:0] get_txt[3] = '{hrbp_pkg::CH_G, hrbp_pkg::CH_E, hrbp_pkg::CH_T};
    logic [7:0] post_txt[4] = '{hrbp_pkg::CH_P, hrbp_pkg::CH_O, hrbp_pkg::CH_S,
                                hrbp_pkg::CH_T};

    function automatic void restart_parse();
        pst       = PS_START;
        meth_len  = '0;
        meth_cand = 2'b11;
        meth_seen = hrbp_pkg::METH_UNKNOWN;
        skip_lead = 1'b0;
        meth_bad  = 1'b0;
        body_cnt  = '0;
    endfunction

    // narrow down GET/POST candidates by one method character
    function automatic void method_char(input logic [7:0] ch);
        if (meth_len >= hrbp_pkg::GET_LEN)
            meth_cand[hrbp_pkg::MATCH_GET] = 1'b0;
        else if (ch != get_txt[meth_len[1:0]])
            meth_cand[hrbp_pkg::MATCH_GET] = 1'b0;
        if (meth_len >= hrbp_pkg::POST_LEN)
            meth_cand[hrbp_pkg::MATCH_POST] = 1'b0;
        else if (ch != post_txt[meth_len[1:0]])
            meth_cand[hrbp_pkg::MATCH_POST] = 1'b0;
        if (meth_len != 3'd7)
            meth_len = meth_len + 3'd1;
    endfunction

    // label one accepted byte and advance the parse state
    function automatic t_label classify_byte(input logic [7:0] ch, input logic is_last);
        t_label r;
        r.cls  = hrbp_pkg::CLS_IGNORED;
        r.fend = 1'b0;
        if (!meth_bad) begin
            case (pst)
                PS_START: begin
                    method_char(ch);
                    r.cls = hrbp_pkg::CLS_METHOD;
                    pst   = PS_METHOD;
                end
                PS_METHOD: begin
                    if (ch == hrbp_pkg::CH_SP) begin
                        r.fend = 1'b1;
                        if (meth_len == hrbp_pkg::GET_LEN) begin
                            if (meth_cand[hrbp_pkg::MATCH_GET])
                                meth_seen = hrbp_pkg::METH_GET;
                        end else if (meth_len == hrbp_pkg::POST_LEN) begin
                            if (meth_cand[hrbp_pkg::MATCH_POST])
                                meth_seen = hrbp_pkg::METH_POST;
                        end else begin
                            meth_bad = 1'b1;
                        end
                        pst = PS_PATH;
                    end else begin
                        method_char(ch);
                        r.cls = hrbp_pkg::CLS_METHOD;
                    end
                end
                PS_PATH: begin
                    if (ch == hrbp_pkg::CH_SP) begin
                        r.fend = 1'b1;
                        pst    = PS_GAP;
                    end else begin
                        r.cls = hrbp_pkg::CLS_PATH;
                    end
                end
                PS_GAP: begin
                    if (ch != hrbp_pkg::CH_SP) begin
                        pst = PS_PROTO;
                        if (ch != hrbp_pkg::CH_CR)
                            r.cls = hrbp_pkg::CLS_PROTO;
                    end
                end
                PS_PROTO: begin
                    if (ch == hrbp_pkg::CH_LF)
                        pst = PS_HNAME;
                    else if (ch != hrbp_pkg::CH_CR)
                        r.cls = hrbp_pkg::CLS_PROTO;
                end
                PS_HNAME: begin
                    if (ch == hrbp_pkg::CH_LF) begin
                        pst = PS_BODY;
                    end else if (ch == hrbp_pkg::CH_COLON) begin
                        r.fend    = 1'b1;
                        skip_lead = 1'b1;
                        pst       = PS_HVALUE;
                    end else if (ch != hrbp_pkg::CH_CR) begin
                        r.cls = hrbp_pkg::CLS_HNAME;
                    end
                end
                PS_HVALUE: begin
                    if (skip_lead && ch == hrbp_pkg::CH_SP) begin
                        r.cls = hrbp_pkg::CLS_IGNORED;
                    end else if (ch == hrbp_pkg::CH_LF) begin
                        r.fend    = 1'b1;
                        skip_lead = 1'b0;
                        pst       = PS_HNAME;
                    end else begin
                        skip_lead = 1'b0;
                        if (ch != hrbp_pkg::CH_CR)
                            r.cls = hrbp_pkg::CLS_HVALUE;
                    end
                end
                default: begin
                    r.cls = hrbp_pkg::CLS_BODY;
                    if (body_cnt != 16'hFFFF)
                        body_cnt = body_cnt + 16'd1;
                end
            endcase
        end
        r.data  = ch;
        r.meth  = meth_seen;
        r.err   = meth_bad;
        r.count = body_cnt;
        r.last  = is_last;
        if (is_last)
            restart_parse();
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // idle percentage per phase: receiver idles more, then sender idles more, then none
    function automatic int idle_pct(input bit rx_side);
        if (accepted < mark1)
            return rx_side ? 59 : 38;
        else if (accepted < mark2)
            return rx_side ? 38 : 59;
        return 0;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic is_last);
        request_bytes.push_back(t_req_byte'{data: b, last: is_last});
    endfunction

    function automatic void push_text(input string s, input bit ends);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], ends && (i == s.len() - 1));
    endfunction

    function automatic logic [7:0] printable();
        return 8'($urandom_range(33, 126));
    endfunction

    function automatic logic [7:0] letter();
        return $urandom_range(1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
    endfunction

    // letters that make near-miss methods likely
    function automatic logic [7:0] method_letter();
        case ($urandom_range(6))
            0: return hrbp_pkg::CH_G;
            1: return hrbp_pkg::CH_E;
            2: return hrbp_pkg::CH_T;
            3: return hrbp_pkg::CH_P;
            4: return hrbp_pkg::CH_O;
            5: return hrbp_pkg::CH_S;
            default: return letter();
        endcase
    endfunction

    // one random request: mostly well formed, some cut short, some pure noise
    task automatic gen_request();
        logic [7:0] txt[$];
        int         n_hdr;
        int         keep;
        bit         in_body;
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom));
        end else begin
            case ($urandom_range(5))
                0: begin
                    txt.push_back(hrbp_pkg::CH_G); txt.push_back(hrbp_pkg::CH_E);
                    txt.push_back(hrbp_pkg::CH_T);
                end
                1: begin
                    txt.push_back(hrbp_pkg::CH_P); txt.push_back(hrbp_pkg::CH_O);
                    txt.push_back(hrbp_pkg::CH_S); txt.push_back(hrbp_pkg::CH_T);
                end
                default: repeat ($urandom_range(1, 9)) txt.push_back(method_letter());
            endcase
            txt.push_back(hrbp_pkg::CH_SP);
            // path and the spaces after it
            txt.push_back("/");
            repeat ($urandom_range(0, 6)) txt.push_back(printable());
            repeat (($urandom_range(3) == 0) ? $urandom_range(2, 3) : 1)
                txt.push_back(hrbp_pkg::CH_SP);
            // protocol line, stray carriage returns allowed
            repeat ($urandom_range(1, 8))
                txt.push_back(($urandom_range(5) == 0) ? hrbp_pkg::CH_CR : printable());
            if ($urandom_range(1))
                txt.push_back(hrbp_pkg::CH_CR);
            txt.push_back(hrbp_pkg::CH_LF);
            // header lines; a line without colon starts the body
            in_body = 1'b0;
            n_hdr = $urandom_range(0, 3);
            for (int h = 0; h < n_hdr && !in_body; h++) begin
                repeat ($urandom_range(1, 6))
                    txt.push_back(($urandom_range(9) == 0) ? hrbp_pkg::CH_CR : letter());
                if ($urandom_range(9) == 0) begin
                    in_body = 1'b1;
                end else begin
                    txt.push_back(hrbp_pkg::CH_COLON);
                    repeat ($urandom_range(0, 2)) txt.push_back(hrbp_pkg::CH_SP);
                    repeat ($urandom_range(0, 6)) begin
                        if ($urandom_range(7) == 0)
                            txt.push_back($urandom_range(1) ? hrbp_pkg::CH_SP
                                                            : hrbp_pkg::CH_CR);
                        else
                            txt.push_back(printable());
                    end
                    if ($urandom_range(1))
                        txt.push_back(hrbp_pkg::CH_CR);
                end
                txt.push_back(hrbp_pkg::CH_LF);
            end
            if (!in_body)
                txt.push_back(hrbp_pkg::CH_LF);
            repeat ($urandom_range(0, 8)) txt.push_back(8'($urandom));
            // broken request: end it early
            if ($urandom_range(99) < 15) begin
                keep = $urandom_range(1, txt.size());
                while (txt.size() > keep)
                    void'(txt.pop_back());
            end
        end
        foreach (txt[i])
            push_byte(txt[i], i == txt.size() - 1);
    endtask

    // input side: offer the next item at the falling edge
    always @(negedge i_clk) begin : driver
        t_req_byte nxt;
        if (i_rst_n && (!i_in_valid || byte_taken)) begin
            if (request_bytes.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                nxt = request_bytes.pop_front();
                i_in_byte  <= nxt.data;
                i_in_last  <= nxt.last;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output side ready, with the long hold-off on top
    always @(negedge i_clk) begin
        i_out_ready <= !rx_hold && ($urandom_range(99) >= idle_pct(1'b1));
    end

    // check result items and predict labels for accepted items
    always @(posedge i_clk) begin : monitor
        t_label want;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_labels.size() == 0) begin
                    $error("result item with no item pending, byte %0h", o_out_byte);
                    fail_cnt++;
                end else begin
                    want = expected_labels.pop_front();
                    check_field("out_byte", 16'(want.data), 16'(o_out_byte));
                    check_field("byte_class", 16'(want.cls), 16'(o_byte_class));
                    check_field("field_end", 16'(want.fend), 16'(o_field_end));
                    check_field("method_code", 16'(want.meth), 16'(o_method_code));
                    check_field("method_error", 16'(want.err), 16'(o_method_error));
                    check_field("body_count", want.count, o_body_count);
                    check_field("out_last", 16'(want.last), 16'(o_out_last));
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_labels.push_back(classify_byte(i_in_byte, i_in_last));
                byte_taken = 1'b1;
                accepted++;
            end
        end
    end

    // receiver stalls for a long stretch so the input backs up
    initial begin
        wait (stim_ready);
        while (accepted < mark2 + 10)
            @(posedge i_clk);
        rx_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin : stimulus
        int n_dir;
        int n_rand;
        restart_parse();
        // directed: GET with gap spaces, carriage returns, header, bare line feed
        push_text("GET /a  H\015\nK: \015v\n\nb", 1'b1);
        // leading space as method character, bad method length
        push_text(" A c", 1'b1);
        // POST with byte extremes in the path
        push_text("POST ", 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        n_dir = request_bytes.size();
        while (request_bytes.size() - n_dir < 1100)
            gen_request();
        n_rand = request_bytes.size() - n_dir;
        mark1 = n_dir + n_rand / 3;
        mark2 = n_dir + 2 * n_rand / 3;
        total_items = request_bytes.size();
        stim_ready = 1'b1;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted < total_items || expected_labels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (fail_cnt == 0 && expected_labels.size() == 0)
            $display("http_request_byte_parser_core: match");
        else
            $display("http_request_byte_parser_core: mismatch");
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("http_request_byte_parser_core: mismatch");
        $finish;
    end

endmodule

>>> http_request_byte_parser_core.f
hdl/hrbp_pkg.sv
hdl/http_request_byte_parser_core.sv
sim/http_request_byte_parser_core_test.sv
